// ===== rtl/ctb_pkg.sv =====
`default_nettype none

package ctb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int TIMER_IDX_W = 3;
  localparam int LIVE_W      = 10;
  localparam int PERIOD_W    = 15;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] OFF_BACKUP = 2'd0;
  localparam logic [1:0] OFF_CTRL   = 2'd1;
  localparam logic [1:0] OFF_COUNT  = 2'd2;
  localparam logic [1:0] OFF_SPARE  = 2'd3;

  localparam logic [5:0] SEL_STATUS = 6'd32;

  // control byte fields
  localparam int CTRL_IRQ_EN_BIT = 7;
  localparam int CTRL_RELOAD_BIT = 4;
  localparam int CTRL_ENABLE_BIT = 3;
  localparam logic [2:0] SRC_LINKED = 3'd7;

  localparam logic [TIMER_IDX_W-1:0] LINK_ONLY_TIMER = 3'd4;
  localparam logic [LIVE_W-1:0]      LIVE_PARKED     = 10'h3FF;

  typedef logic [TIMER_IDX_W-1:0] timer_idx_t;

  typedef struct packed {
    logic       valid;
    timer_idx_t idx;
  } succ_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] dec;
    logic                le_one;
    logic                zero;
  } step_res_t;

  function automatic succ_t successor_of(input timer_idx_t t);
    succ_t s;
    s.valid = 1'b1;
    case (t)
      3'd0:    s.idx = 3'd2;
      3'd2:    s.idx = 3'd4;
      3'd1:    s.idx = 3'd3;
      3'd3:    s.idx = 3'd5;
      3'd5:    s.idx = 3'd7;
      default: begin
        s.valid = 1'b0;
        s.idx   = 3'd0;
      end
    endcase
    return s;
  endfunction

  function automatic logic [PERIOD_W-1:0] period_of(input logic [7:0] backup,
                                                    input logic [2:0] src);
    logic [8:0]  base;
    logic [16:0] wide;
    base = (backup == 8'd0) ? 9'd256 : {1'b0, backup};
    wide = {8'd0, base} << src;
    return wide[PERIOD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ctb_in_if.sv =====
`default_nettype none

interface ctb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, output cmd, output reg_select, output write_data,
                  input ready);
  modport sink (input valid, input cmd, input reg_select, input write_data,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ctb_out_if.sv =====
`default_nettype none

interface ctb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_pulse;
  logic [7:0] irq_status;

  modport source (output valid, output read_data, output irq_pulse, output irq_status,
                  input ready);
  modport sink (input valid, input read_data, input irq_pulse, input irq_status,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ctb_step_unit.sv =====
`default_nettype none

// shared decrement and compare for period and linked counters
module ctb_step_unit (
  input  logic [ctb_pkg::PERIOD_W-1:0] operand,
  output ctb_pkg::step_res_t           res
);

  always_comb begin
    res.dec    = operand - ctb_pkg::PERIOD_W'(1);
    res.le_one = (operand <= ctb_pkg::PERIOD_W'(1));
    res.zero   = (operand == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/cascaded_timer_bank.sv =====
`default_nettype none

// Channel  | Dir | Payload                                 | Handshake
// in_ch    | in  | cmd, reg_select, write_data             | valid/ready
// out_ch   | out | read_data, irq_pulse, irq_status        | valid/ready
//
// Read and write items pass S_EXEC, S_RESTART (timer-register writes only) and
// S_FIN to the result register. A tick visits the eight timers in S_SCAN through
// one shared decrement/compare unit, stepping each expiring timer's chain in S_CHAIN.
// Synchronous active-low reset clears all timer state and the status byte.
// A new item is accepted while a finished result still waits on out_ch.
module cascaded_timer_bank (
  input  logic      clk,
  input  logic      rst_n,
  ctb_in_if.sink    in_ch,
  ctb_out_if.source out_ch
);

  localparam int N  = ctb_pkg::NUM_TIMERS;
  localparam int LW = ctb_pkg::LIVE_W;
  localparam int PW = ctb_pkg::PERIOD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RESTART, S_SCAN, S_CHAIN, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    backup_r [N];
  logic [7:0]    backup_nxt [N];
  logic [7:0]    ctrl_r [N];
  logic [7:0]    ctrl_nxt [N];
  logic [7:0]    spare_r [N];
  logic [7:0]    spare_nxt [N];
  logic [LW-1:0] live_r [N];
  logic [LW-1:0] live_nxt [N];
  logic [PW-1:0] left_r [N];
  logic [PW-1:0] left_nxt [N];
  logic [N-1:0]  active_r, active_nxt;
  logic [7:0]    status_r, status_nxt;

  logic [1:0] cmd_r, cmd_nxt;
  logic [5:0] sel_r, sel_nxt;
  logic [7:0] wd_r, wd_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       pulse_r, pulse_nxt;

  ctb_pkg::timer_idx_t scan_r, scan_nxt;
  ctb_pkg::timer_idx_t chain_r, chain_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rd_r, out_rd_nxt;
  logic       out_pulse_r, out_pulse_nxt;
  logic [7:0] out_status_r, out_status_nxt;

  ctb_pkg::timer_idx_t cur;
  logic [PW-1:0]       operand;
  ctb_pkg::step_res_t  step;
  ctb_pkg::succ_t      succ;
  logic                last_scan;
  logic                in_fire;

  assign cur       = (state_r == S_CHAIN) ? chain_r : scan_r;
  assign operand   = (state_r == S_CHAIN) ? {{(PW-LW){1'b0}}, live_r[cur]} : left_r[cur];
  assign succ      = ctb_pkg::successor_of(cur);
  assign last_scan = (scan_r == ctb_pkg::TIMER_IDX_W'(N-1));
  assign in_fire   = in_ch.valid && in_ch.ready;

  ctb_step_unit u_step (
    .operand (operand),
    .res     (step)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rd_r;
  assign out_ch.irq_pulse  = out_pulse_r;
  assign out_ch.irq_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    backup_nxt     = backup_r;
    ctrl_nxt       = ctrl_r;
    spare_nxt      = spare_r;
    live_nxt       = live_r;
    left_nxt       = left_r;
    active_nxt     = active_r;
    status_nxt     = status_r;
    cmd_nxt        = cmd_r;
    sel_nxt        = sel_r;
    wd_nxt         = wd_r;
    rd_nxt         = rd_r;
    pulse_nxt      = pulse_r;
    scan_nxt       = scan_r;
    chain_nxt      = chain_r;
    out_valid_nxt  = out_valid_r;
    out_rd_nxt     = out_rd_r;
    out_pulse_nxt  = out_pulse_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_ch.cmd;
          sel_nxt   = in_ch.reg_select;
          wd_nxt    = in_ch.write_data;
          rd_nxt    = 8'd0;
          pulse_nxt = 1'b0;
          if (in_ch.cmd == ctb_pkg::CMD_TICK) begin
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end else begin
            scan_nxt  = in_ch.reg_select[4:2];
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        case (cmd_r)
          ctb_pkg::CMD_READ: begin
            if (sel_r < ctb_pkg::SEL_STATUS) begin
              case (sel_r[1:0])
                ctb_pkg::OFF_BACKUP: rd_nxt = backup_r[cur];
                ctb_pkg::OFF_CTRL:   rd_nxt = ctrl_r[cur];
                ctb_pkg::OFF_COUNT:  rd_nxt = live_r[cur][7:0];
                default:             rd_nxt = spare_r[cur];
              endcase
            end else if (sel_r == ctb_pkg::SEL_STATUS) begin
              rd_nxt = status_r;
            end
          end
          ctb_pkg::CMD_WRITE: begin
            if (sel_r < ctb_pkg::SEL_STATUS) begin
              state_nxt = S_RESTART;
              case (sel_r[1:0])
                ctb_pkg::OFF_BACKUP: begin
                  backup_nxt[cur] = wd_r;
                  live_nxt[cur]   = {2'b00, wd_r} + LW'(1);
                end
                ctb_pkg::OFF_CTRL:  ctrl_nxt[cur] = wd_r;
                ctb_pkg::OFF_COUNT: ;
                default:            spare_nxt[cur] = wd_r;
              endcase
            end else if (sel_r == ctb_pkg::SEL_STATUS) begin
              status_nxt = wd_r;
            end
          end
          default: ;
        endcase
      end

      S_RESTART: begin
        state_nxt = S_FIN;
        if (ctrl_r[cur][ctb_pkg::CTRL_ENABLE_BIT] && cur != ctb_pkg::LINK_ONLY_TIMER &&
            ctrl_r[cur][2:0] != ctb_pkg::SRC_LINKED) begin
          active_nxt[cur] = 1'b1;
          left_nxt[cur]   = ctb_pkg::period_of(backup_r[cur], ctrl_r[cur][2:0]);
        end else begin
          active_nxt[cur] = 1'b0;
          left_nxt[cur]   = '0;
        end
      end

      S_SCAN: begin
        if (active_r[cur] && step.le_one) begin
          if (ctrl_r[cur][ctb_pkg::CTRL_IRQ_EN_BIT]) begin
            status_nxt = status_r | (8'd1 << cur);
            pulse_nxt  = 1'b1;
          end
          if (ctrl_r[cur][ctb_pkg::CTRL_RELOAD_BIT]) begin
            left_nxt[cur] = ctb_pkg::period_of(backup_r[cur], ctrl_r[cur][2:0]);
          end else begin
            active_nxt[cur] = 1'b0;
            left_nxt[cur]   = '0;
          end
        end else if (active_r[cur]) begin
          left_nxt[cur] = step.dec;
        end

        if (active_r[cur] && step.le_one && succ.valid) begin
          chain_nxt = succ.idx;
          state_nxt = S_CHAIN;
        end else if (last_scan) begin
          state_nxt = S_FIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_CHAIN: begin
        if (ctrl_r[cur][2:0] == ctb_pkg::SRC_LINKED && !live_r[cur][LW-1] && step.zero) begin
          live_nxt[cur] = ctrl_r[cur][ctb_pkg::CTRL_RELOAD_BIT] ?
                          {2'b00, backup_r[cur]} : ctb_pkg::LIVE_PARKED;
          if (ctrl_r[cur][ctb_pkg::CTRL_IRQ_EN_BIT]) begin
            status_nxt = status_r | (8'd1 << cur);
            pulse_nxt  = 1'b1;
          end
          if (succ.valid) begin
            chain_nxt = succ.idx;
          end else if (last_scan) begin
            state_nxt = S_FIN;
          end else begin
            scan_nxt  = scan_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          if (ctrl_r[cur][2:0] == ctb_pkg::SRC_LINKED && !live_r[cur][LW-1]) begin
            live_nxt[cur] = step.dec[LW-1:0];
          end
          if (last_scan) begin
            state_nxt = S_FIN;
          end else begin
            scan_nxt  = scan_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = rd_r;
          out_pulse_nxt  = pulse_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      status_r    <= 8'd0;
      scan_r      <= '0;
      chain_r     <= '0;
      for (int i = 0; i < N; i++) begin
        backup_r[i] <= 8'd0;
        ctrl_r[i]   <= 8'd0;
        spare_r[i]  <= 8'd0;
        live_r[i]   <= '0;
        left_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      status_r    <= status_nxt;
      scan_r      <= scan_nxt;
      chain_r     <= chain_nxt;
      backup_r    <= backup_nxt;
      ctrl_r      <= ctrl_nxt;
      spare_r     <= spare_nxt;
      live_r      <= live_nxt;
      left_r      <= left_nxt;
    end
    cmd_r        <= cmd_nxt;
    sel_r        <= sel_nxt;
    wd_r         <= wd_nxt;
    rd_r         <= rd_nxt;
    pulse_r      <= pulse_nxt;
    out_rd_r     <= out_rd_nxt;
    out_pulse_r  <= out_pulse_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire
